// ===== rtl/bafp_pkg.sv =====
`timescale 1ns / 1ps

package bafp_pkg;

  localparam int PRESS_W = 19;
  localparam int TEMP_W  = 13;
  localparam int TK_W    = 14;
  localparam int ALT_W   = 32;

  // R/g times ten in Q15, and ln(2) in Q31.
  localparam int RG_W  = 24;
  localparam int LN2_W = 31;
  localparam logic [RG_W-1:0]  R_OVER_G_Q15 = 24'd9591506;
  localparam logic [LN2_W-1:0] LN2_Q31      = 31'h58B9_0BFC;

  // Kelvin offset (273.1 K) less the sensor's 40 C offset, in tenths.
  localparam logic [TK_W-1:0] KELVIN_ADJ = 14'd2331;

  typedef logic [PRESS_W-1:0] press_t;
  typedef logic [TEMP_W-1:0]  temp_t;
  typedef logic [TK_W-1:0]    temp_k10_t;
  typedef logic [ALT_W-1:0]   alt_t;

endpackage

// ===== rtl/bafp_ifs.sv =====
`timescale 1ns / 1ps

interface bafp_in_if;
  import bafp_pkg::*;

  logic  valid;
  logic  ready;
  press_t pressure_pa;
  temp_t  temp_raw;

  modport source (output valid, output pressure_pa, output temp_raw, input ready);
  modport sink   (input valid, input pressure_pa, input temp_raw, output ready);
endinterface

interface bafp_out_if;
  import bafp_pkg::*;

  logic valid;
  logic ready;
  alt_t altitude_cm;

  modport source (output valid, output altitude_cm, input ready);
  modport sink   (input valid, input altitude_cm, output ready);
endinterface

// ===== rtl/baro_altitude_fixed_point_core.sv =====
`timescale 1ns / 1ps

// Barometric altitude core. Each transaction on in_ch carries a pressure in
// pascal and a raw temperature; one transaction on out_ch returns the altitude
// in centimetres relative to the first nonzero-pressure sample, which is kept
// as the ground reference until reset. A zero pressure returns 0 and does not
// capture a reference. One 32x32 multiplier is shared by every product and a
// restoring divider forms the pressure ratio one quotient bit per cycle; the
// ratio is then normalized by single-bit shifts and its log found by repeated
// squaring before the result is loaded into the output register. A ratio that
// wraps to zero ends after the divider, and a zero pressure skips the
// arithmetic. The input is not ready while a sample is in work, but a finished
// result may wait in the output register while the next sample is accepted.
module baro_altitude_fixed_point_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  bafp_in_if.sink     in_ch,
  bafp_out_if.source  out_ch
);
  import bafp_pkg::*;

  localparam int ZW  = FRAC_BITS + 1;
  localparam int YIW = 6;
  localparam int YW  = YIW + FRAC_BITS;
  localparam int SCW = RG_W + TK_W - FRAC_BITS;
  localparam int LNW = FRAC_BITS + 6;
  localparam int MW  = 32;
  localparam int QW  = 32;
  localparam int CW  = 5;
  localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);
  localparam logic [CW-1:0] SQR_LAST = CW'(FRAC_BITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_SQR   = 3'd4;
  localparam logic [2:0] S_LNM   = 3'd5;
  localparam logic [2:0] S_FINM  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  press_t          ref_p_r, ref_p_nxt;
  temp_k10_t       ref_tk_r, ref_tk_nxt;
  press_t          p_r, p_nxt;
  temp_k10_t       tk_r, tk_nxt;
  logic [SCW-1:0]  scale_r, scale_nxt;
  logic [QW-1:0]   dq_r, dq_nxt;
  press_t          rem_r, rem_nxt;
  logic [YIW-1:0]  yi_r, yi_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [ZW-1:0]   z_r, z_nxt;
  logic [LNW-1:0]  ln_r, ln_nxt;
  logic            neg_r, neg_nxt;
  alt_t            mag_r, mag_nxt;
  logic            out_valid_r, out_valid_nxt;
  alt_t            out_alt_r, out_alt_nxt;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic            in_fire;
  temp_k10_t       tk_in;
  logic [TK_W:0]   tsum;
  logic [63:0]     num_full;
  logic [PRESS_W:0] rem_sh;
  logic            div_ge;
  logic [FRAC_BITS+1:0] sq_t;
  logic [YW-1:0]   y_val, y_mag;
  logic [2*MW-1:0] ln_sum;
  logic            out_free;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.altitude_cm = out_alt_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign tk_in    = TK_W'(in_ch.temp_raw) + KELVIN_ADJ;
  assign tsum     = {1'b0, ref_tk_r} + {1'b0, tk_r};
  // The reference pressure is pre-scaled in a 32-bit register, so its top
  // bits wrap away when the shifted value needs more than 32 bits.
  assign num_full = {{(64 - PRESS_W){1'b0}}, ref_p_r} << (FRAC_BITS - 1);
  assign rem_sh   = {rem_r, dq_r[QW-1]};
  assign div_ge   = rem_sh >= {1'b0, p_r};
  assign sq_t     = mul_p[FRAC_BITS +: FRAC_BITS + 2];
  assign y_val    = {yi_r, frac_r};
  assign y_mag    = yi_r[YIW-1] ? YW'(~y_val + 1'b1) : y_val;
  // A negative log rounds toward minus infinity: round the magnitude up.
  assign ln_sum   = mul_p + (yi_r[YIW-1] ? 64'h0000_0000_7FFF_FFFF : 64'd0);
  assign out_free = !out_valid_r || out_ch.ready;

  // Shared multiplier.
  always_comb begin
    case (state_r)
      S_SCALE: begin
        mul_a = MW'(R_OVER_G_Q15);
        mul_b = MW'(tsum[TK_W:1]);
      end
      S_SQR: begin
        mul_a = MW'(z_r);
        mul_b = MW'(z_r);
      end
      S_LNM: begin
        mul_a = MW'(y_mag);
        mul_b = MW'(LN2_Q31);
      end
      S_FINM: begin
        mul_a = MW'(scale_r);
        mul_b = MW'(ln_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ref_p_nxt     = ref_p_r;
    ref_tk_nxt    = ref_tk_r;
    p_nxt         = p_r;
    tk_nxt        = tk_r;
    scale_nxt     = scale_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    yi_nxt        = yi_r;
    frac_nxt      = frac_r;
    z_nxt         = z_r;
    ln_nxt        = ln_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_alt_nxt   = out_alt_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          p_nxt  = in_ch.pressure_pa;
          tk_nxt = tk_in;
          if (in_ch.pressure_pa == '0) begin
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            if (ref_p_r == '0) begin
              ref_p_nxt  = in_ch.pressure_pa;
              ref_tk_nxt = tk_in;
            end
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        scale_nxt = mul_p[FRAC_BITS +: SCW];
        dq_nxt    = num_full[QW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? PRESS_W'(rem_sh - {1'b0, p_r}) : rem_sh[PRESS_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          // Final quotient bit, then the extra doubling of the ratio.
          dq_nxt = {dq_r[QW-3:0], div_ge, 1'b0};
          yi_nxt = '0;
          if ({dq_r[QW-3:0], div_ge} == '0) begin
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_NORM;
          end
        end else begin
          dq_nxt = {dq_r[QW-2:0], div_ge};
        end
      end
      S_NORM: begin
        if (dq_r[QW-1:FRAC_BITS] == '0) begin
          dq_nxt = {dq_r[QW-2:0], 1'b0};
          yi_nxt = yi_r - 1'b1;
        end else if (|dq_r[QW-1:FRAC_BITS+1]) begin
          dq_nxt = {1'b0, dq_r[QW-1:1]};
          yi_nxt = yi_r + 1'b1;
        end else begin
          z_nxt     = dq_r[ZW-1:0];
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        // Squaring doubles the log; a square of two or more yields a one bit.
        if (sq_t[FRAC_BITS+1]) begin
          z_nxt    = sq_t[FRAC_BITS+1:1];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          z_nxt    = sq_t[FRAC_BITS:0];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQR_LAST) begin
          state_nxt = S_LNM;
        end
      end
      S_LNM: begin
        ln_nxt    = ln_sum[31 +: LNW];
        neg_nxt   = yi_r[YIW-1];
        state_nxt = S_FINM;
      end
      S_FINM: begin
        mag_nxt   = mul_p[FRAC_BITS +: ALT_W];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_alt_nxt   = neg_r ? ALT_W'(~mag_r + 1'b1) : mag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ref_p_r     <= '0;
      ref_tk_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ref_p_r     <= ref_p_nxt;
      ref_tk_r    <= ref_tk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    tk_r      <= tk_nxt;
    scale_r   <= scale_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    yi_r      <= yi_nxt;
    frac_r    <= frac_nxt;
    z_r       <= z_nxt;
    ln_r      <= ln_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    out_alt_r <= out_alt_nxt;
  end

endmodule

// ===== tb/bafp_altitude_checker.sv =====
`timescale 1ns / 1ps

module bafp_altitude_checker #(
  parameter int FRAC_BITS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  bafp_pkg::press_t in_pressure_pa,
  input  bafp_pkg::temp_t  in_temp_raw,
  input  logic            out_valid,
  input  logic            out_ready,
  input  bafp_pkg::alt_t   out_altitude_cm,
  output int              fail_count,
  output int              pending,
  output int              results_seen
);
  import bafp_pkg::*;

  typedef struct {
    press_t pressure;
    temp_t  temp;
    alt_t   altitude;
  } alt_expect_t;

  alt_expect_t expected_alt[$];

  // Ground reference; a zero pressure means nothing has been captured yet.
  press_t    ground_press;
  temp_k10_t ground_tk;

  // log2 in Q(FRAC_BITS): normalize into [1, 2), then square repeatedly.
  function automatic longint fixed_log2(input logic [31:0] x);
    longint      y;
    longint      bit_weight;
    logic [63:0] v;
    int          i;
    y = 0;
    bit_weight = longint'(1) << (FRAC_BITS - 1);
    v = 64'(x);
    while (v < (64'd1 << FRAC_BITS)) begin
      v = v << 1;
      y -= longint'(1) << FRAC_BITS;
    end
    while (v >= (64'd2 << FRAC_BITS)) begin
      v = v >> 1;
      y += longint'(1) << FRAC_BITS;
    end
    for (i = 0; i < FRAC_BITS; i++) begin
      v = (v * v) >> FRAC_BITS;
      if (v >= (64'd2 << FRAC_BITS)) begin
        v = v >> 1;
        y += bit_weight;
      end
      bit_weight = bit_weight >>> 1;
    end
    return y;
  endfunction

  function automatic alt_t predict_altitude(input press_t p, input temp_t t);
    logic [15:0] tk;
    logic [16:0] tmean;
    logic [63:0] scale;
    logic [63:0] numer;
    logic [31:0] ratio;
    longint      prod;
    longint      ln_q;
    logic        below;
    alt_t        mag;
    if (p == '0) return '0;
    tk = {3'd0, t} + {2'd0, KELVIN_ADJ};
    if (ground_press == '0) begin
      ground_press = p;
      ground_tk = tk[TK_W-1:0];
    end
    tmean = ({3'd0, ground_tk} + {1'b0, tk}) >> 1;
    scale = (64'(R_OVER_G_Q15) * 64'(tmean)) >> FRAC_BITS;
    // The shifted ground pressure lives in a 32-bit register and wraps.
    numer = 64'(ground_press) << (FRAC_BITS - 1);
    ratio = numer[31:0] / {13'd0, p};
    ratio = ratio << 1;
    if (ratio == '0) return '0;
    prod = fixed_log2(ratio) * longint'(LN2_Q31);
    ln_q = prod >>> 31;
    below = ln_q < 0;
    if (below) ln_q = -ln_q;
    scale = (scale * 64'(ln_q)) >> FRAC_BITS;
    mag = scale[ALT_W-1:0];
    if (below) mag = -mag;
    return mag;
  endfunction

  always @(posedge clk) begin
    alt_expect_t exp_item;
    if (rst_n !== 1'b1) begin
      ground_press = '0;
      ground_tk = '0;
      expected_alt.delete();
    end else begin
      // Retire a result before queueing a new sample from the same edge.
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        results_seen++;
        if (expected_alt.size() == 0) begin
          $display("%0t: altitude %0d cm arrived with no sample outstanding",
                   $time, $signed(out_altitude_cm));
          fail_count++;
        end else begin
          exp_item = expected_alt.pop_front();
          if (out_altitude_cm !== exp_item.altitude) begin
            $display("%0t: wrong altitude for %0d Pa, temp %0d: expected %0d, got %0d",
                     $time, exp_item.pressure, exp_item.temp,
                     $signed(exp_item.altitude), $signed(out_altitude_cm));
            fail_count++;
          end
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        exp_item.pressure = in_pressure_pa;
        exp_item.temp = in_temp_raw;
        exp_item.altitude = predict_altitude(in_pressure_pa, in_temp_raw);
        expected_alt.push_back(exp_item);
      end
    end
    pending <= expected_alt.size();
  end

endmodule

// ===== tb/baro_altitude_fixed_point_core_test.sv =====
`timescale 1ns / 1ps

module baro_altitude_fixed_point_core_test;
  import bafp_pkg::*;

  localparam int FRAC_BITS      = 15;
  localparam int CYCLE_LIMIT    = 1_200_000;
  localparam int RANDOM_SAMPLES = 1300;
  localparam int DRAIN_CYCLES   = 150;

  // Bit 18 set makes the shifted reference wrap, and a pressure of 1 then
  // gives a ratio of exactly 2^31, which wraps to zero on the final shift.
  localparam press_t GROUND_PA = 19'h60000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   samples_sent = 0;
  int   zero_samples = 0;
  int   burst_left = 0;
  int   fail_count;
  int   pending;
  int   results_seen;

  bafp_in_if  in_ch ();
  bafp_out_if out_ch ();

  baro_altitude_fixed_point_core #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  bafp_altitude_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_pressure_pa (in_ch.pressure_pa),
    .in_temp_raw    (in_ch.temp_raw),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_altitude_cm(out_ch.altitude_cm),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycles);
      $display("baro_altitude_fixed_point_core: mismatch");
      $finish;
    end
  end

  // The receiver switches at random between four behaviors: always
  // ready, coin flip, mostly stalled, or long stalls with short openings.
  initial begin
    int mode;
    int left;
    left = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ch.ready <= ((left % 32) < 2);
        end
      endcase
    end
  end

  // Holds valid until the transaction completes. Between bursts valid drops
  // for a random gap while the payload carries junk.
  task automatic send_sample(input press_t p, input temp_t t);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.pressure_pa <= p;
    in_ch.temp_raw <= t;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    samples_sent++;
    if (p == '0) zero_samples++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      in_ch.pressure_pa <= PRESS_W'($urandom);
      in_ch.temp_raw <= TEMP_W'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin
    press_t p;
    temp_t  t;
    int     pick;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pressure_pa <= '0;
    in_ch.temp_raw <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero pressure before any reference exists must not capture one.
    send_sample('0, '0);
    send_sample('0, 13'h1FFF);
    send_sample(GROUND_PA, 13'h1FFF);
    send_sample('0, 13'd1234);
    send_sample(19'd1, '0);
    send_sample(19'd1, 13'h1FFF);
    send_sample(19'd2, 13'd4000);
    // Around a ratio of exactly one.
    send_sample(19'h20000, 13'd400);
    send_sample(19'h1FFFF, 13'd400);
    send_sample(19'h20001, 13'd400);
    send_sample(19'h7FFFF, '0);
    send_sample(19'h7FFFF, 13'h1FFF);
    send_sample(GROUND_PA, '0);
    send_sample(19'd101325, 13'd650);
    send_sample(19'd3, 13'd4095);
    send_sample(19'h40000, 13'd100);
    send_sample(19'd16, 13'd5000);
    send_sample(19'h7FFFE, 13'd1);
    send_sample(19'h55555, 13'h0AAA);
    send_sample(19'h2AAAA, 13'h1555);

    repeat (RANDOM_SAMPLES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        p = '0;
      end else if (pick < 45) begin
        p = PRESS_W'($urandom_range(1, 2 ** PRESS_W - 1));
      end else if (pick < 85) begin
        p = PRESS_W'($urandom_range(80000, 180000));
      end else if (pick < 95) begin
        p = PRESS_W'($urandom_range(1, 64));
      end else begin
        p = PRESS_W'($urandom_range(GROUND_PA - 4000, 2 ** PRESS_W - 1));
      end
      if ($urandom_range(0, 1) == 0) begin
        t = TEMP_W'($urandom_range(0, 2 ** TEMP_W - 1));
      end else begin
        t = TEMP_W'($urandom_range(200, 1000));
      end
      send_sample(p, t);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pressure samples (%0d at zero pressure), ground reference %0d Pa,",
             samples_sent, zero_samples, GROUND_PA);
    $display("and checked %0d altitudes under random gaps and output stalls.",
             results_seen);
    if (fail_count == 0) begin
      $display("baro_altitude_fixed_point_core: match");
    end else begin
      $display("%0d altitude errors", fail_count);
      $display("baro_altitude_fixed_point_core: mismatch");
    end
    $finish;
  end

endmodule
